FILE: design/gmi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid mesh index generator package
// Shared widths, register codes, beat and job types, and the pass and
// position functions used by both the walker and the emitter.
// ----------------------------------------------------------------------------
package gmi_pkg;

  localparam int MAX_DIM     = 256;
  localparam int DIM_W       = 9;
  localparam int POS_W       = 8;
  localparam int COORD_W     = 11;
  localparam int STRIDE_W    = 12;
  localparam int IDX_W       = 17;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 9;
  localparam int MAX_RESULTS = 6;
  localparam int CNT_W       = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_COLUMNS = 3'd0,
    REG_GRID_ROWS    = 3'd1,
    REG_START_X      = 3'd2,
    REG_START_Y      = 3'd3,
    REG_END_X        = 3'd4,
    REG_END_Y        = 3'd5,
    REG_MESH_MODE    = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_SMOOTH_TRI  = 2'd0,
    MODE_SMOOTH_LINE = 2'd1,
    MODE_FLAT_TRI    = 2'd2,
    MODE_FLAT_LINE   = 2'd3
  } mesh_mode_t;

  localparam logic PASS_FIRST  = 1'b0;
  localparam logic PASS_SECOND = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;

  localparam coord_t COORD_ONE = coord_t'(1);
  localparam coord_t COORD_TWO = coord_t'(2);

  typedef struct packed {
    logic [DIM_W-1:0] grid_columns;
    logic [DIM_W-1:0] grid_rows;
    logic [POS_W-1:0] start_x;
    logic [POS_W-1:0] start_y;
    logic [POS_W-1:0] end_x;
    logic [POS_W-1:0] end_y;
    mesh_mode_t       mesh_mode;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    grid_columns: DIM_W'(2),
    grid_rows:    DIM_W'(2),
    start_x:      '0,
    start_y:      '0,
    end_x:        POS_W'(1),
    end_y:        POS_W'(1),
    mesh_mode:    MODE_SMOOTH_TRI
  };

  typedef struct packed {
    logic restart;
  } in_beat_t;

  typedef struct packed {
    logic [IDX_W-1:0] vertex_index;
    logic             last_of_item;
    logic             mesh_done;
  } out_beat_t;

  typedef struct packed {
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
  } bounds_t;

  typedef struct packed {
    logic   ph;
    coord_t i;
    coord_t k;
  } pos_t;

  typedef struct packed {
    logic ok;
    pos_t pos;
  } step_t;

  typedef struct packed {
    logic   ok;
    coord_t r0;
    coord_t r1;
    coord_t c0;
    coord_t c1;
  } range_t;

  typedef struct packed {
    pos_t    pos;
    bounds_t bnd;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } job_req_t;

  typedef struct packed {
    logic free;
    logic mesh_end;
  } emit_status_t;

  // Row and column range of one pass; ok is low when the pass does not
  // exist in this mode or its range is empty.
  function automatic range_t pass_range(input logic ph, input mesh_mode_t mode,
                                        input bounds_t bnd);
    range_t rg;
    logic   exists;
    exists = 1'b1;
    rg.ok  = 1'b0;
    rg.r0  = bnd.sy;
    rg.c0  = bnd.sx;
    rg.r1  = bnd.ey;
    rg.c1  = bnd.ex;
    unique case (mode)
      MODE_SMOOTH_TRI: begin
        exists = (ph == PASS_FIRST);
        rg.r1  = bnd.ey - COORD_ONE;
        rg.c1  = bnd.ex - COORD_ONE;
      end
      MODE_SMOOTH_LINE: begin
        if (ph == PASS_FIRST) begin
          rg.c1 = bnd.ex - COORD_ONE;
        end else begin
          rg.r1 = bnd.ey - COORD_ONE;
        end
      end
      MODE_FLAT_TRI: begin
        exists = (ph == PASS_FIRST);
        rg.r1  = bnd.ey - COORD_TWO;
        rg.c1  = bnd.ex - COORD_TWO;
      end
      MODE_FLAT_LINE: begin
        if (ph == PASS_FIRST) begin
          rg.c1 = bnd.ex - COORD_ONE;
        end else begin
          rg.r1 = bnd.ey - COORD_ONE;
          rg.c0 = '0;
          rg.c1 = '0;
        end
      end
      default: exists = 1'b0;
    endcase
    rg.ok = exists && (rg.r0 <= rg.r1) && (rg.c0 <= rg.c1);
    return rg;
  endfunction

  // First position of the first pass that has anything in it.
  function automatic step_t seek_first(input mesh_mode_t mode, input bounds_t bnd);
    range_t g0;
    range_t g1;
    step_t  st;
    g0        = pass_range(PASS_FIRST, mode, bnd);
    g1        = pass_range(PASS_SECOND, mode, bnd);
    st.ok     = g0.ok;
    st.pos.ph = PASS_FIRST;
    st.pos.i  = g0.r0;
    st.pos.k  = g0.c0;
    if (!g0.ok && g1.ok) begin
      st.ok     = 1'b1;
      st.pos.ph = PASS_SECOND;
      st.pos.i  = g1.r0;
      st.pos.k  = g1.c0;
    end
    return st;
  endfunction

  // Position after p: next column, wrapping to the next row, then on to
  // the second pass when the current one is used up.
  function automatic step_t next_pos(input pos_t p, input mesh_mode_t mode,
                                     input bounds_t bnd);
    range_t g;
    range_t g1;
    step_t  st;
    coord_t i;
    coord_t k;
    g  = pass_range(p.ph, mode, bnd);
    g1 = pass_range(PASS_SECOND, mode, bnd);
    k  = p.k + COORD_ONE;
    i  = p.i;
    if (k > g.c1) begin
      k = g.c0;
      i = p.i + COORD_ONE;
    end
    st.pos.ph = p.ph;
    st.pos.i  = i;
    st.pos.k  = k;
    st.ok     = g.ok && (i >= g.r0) && (i <= g.r1) && (k >= g.c0) && (k <= g.c1);
    if (!st.ok && (p.ph == PASS_FIRST) && g1.ok) begin
      st.ok     = 1'b1;
      st.pos.ph = PASS_SECOND;
      st.pos.i  = g1.r0;
      st.pos.k  = g1.c0;
    end
    return st;
  endfunction

endpackage

FILE: design/gmi_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid mesh stream channel
// Valid/ready channel carrying one payload beat of a configurable type.
// ----------------------------------------------------------------------------
interface gmi_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: design/gmi_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid mesh configuration registers
// Decodes register writes and saturates the grid dimensions at MAX_DIM.
// ----------------------------------------------------------------------------
module gmi_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [gmi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gmi_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output gmi_pkg::cfg_t                   cfg
);
  import gmi_pkg::*;

  cfg_t             cfg_r;
  cfg_t             cfg_nxt;
  logic [DIM_W-1:0] dim_sat;

  always_comb begin
    dim_sat = cfg_wdata[DIM_W-1:0];
    if (int'(cfg_wdata[DIM_W-1:0]) > MAX_DIM) begin
      dim_sat = DIM_W'(MAX_DIM);
    end
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_GRID_COLUMNS: cfg_nxt.grid_columns = dim_sat;
        REG_GRID_ROWS:    cfg_nxt.grid_rows    = dim_sat;
        REG_START_X:      cfg_nxt.start_x      = cfg_wdata[POS_W-1:0];
        REG_START_Y:      cfg_nxt.start_y      = cfg_wdata[POS_W-1:0];
        REG_END_X:        cfg_nxt.end_x        = cfg_wdata[POS_W-1:0];
        REG_END_Y:        cfg_nxt.end_y        = cfg_wdata[POS_W-1:0];
        REG_MESH_MODE:    cfg_nxt.mesh_mode    = mesh_mode_t'(cfg_wdata[1:0]);
        default:          cfg_nxt              = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: design/gmi_walker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid mesh walker
// Clamps the region on restart and steps the cell or segment position,
// handing each new position to the emitter as a job.
// ----------------------------------------------------------------------------
module gmi_walker (
  input  logic                  clk,
  input  logic                  rst_n,
  input  gmi_pkg::cfg_t         cfg,
  input  gmi_pkg::emit_status_t status,
  gmi_stream_if.sink            in_if,
  output gmi_pkg::job_req_t     req
);
  import gmi_pkg::*;

  pos_t    pos_r;
  pos_t    pos_nxt;
  bounds_t bnd_r;
  bounds_t bnd_nxt;
  logic    finished_r;
  logic    finished_nxt;

  bounds_t bnd_new;
  step_t   sk;
  step_t   nx;
  logic    accept;
  logic    fin_eff;
  logic    end_form;

  // Last row or column of the region; in end form the bound may reach the
  // dimension itself.
  function automatic coord_t clamp_end(input logic [POS_W-1:0] e,
                                       input logic [DIM_W-1:0] dim,
                                       input logic ef);
    coord_t e_c;
    coord_t d_c;
    e_c = {{(COORD_W-POS_W){1'b0}}, e};
    d_c = {{(COORD_W-DIM_W){1'b0}}, dim};
    if (ef) begin
      return (e_c > d_c) ? d_c : e_c;
    end
    return (e_c >= d_c) ? d_c - COORD_ONE : e_c;
  endfunction

  function automatic coord_t clamp_start(input logic [POS_W-1:0] s, input coord_t e);
    coord_t s_c;
    s_c = {{(COORD_W-POS_W){1'b0}}, s};
    return (s_c > e) ? e - COORD_ONE : s_c;
  endfunction

  assign in_if.ready = status.free;
  assign accept      = in_if.valid && in_if.ready;
  assign end_form    = (cfg.mesh_mode == MODE_FLAT_TRI);

  always_comb begin
    bnd_new.ex = clamp_end(cfg.end_x, cfg.grid_columns, end_form);
    bnd_new.ey = clamp_end(cfg.end_y, cfg.grid_rows, end_form);
    bnd_new.sx = clamp_start(cfg.start_x, bnd_new.ex);
    bnd_new.sy = clamp_start(cfg.start_y, bnd_new.ey);
    sk         = seek_first(cfg.mesh_mode, bnd_new);
    nx         = next_pos(pos_r, cfg.mesh_mode, bnd_r);
    // The job in the emitter may already be the last of the mesh.
    fin_eff    = finished_r || status.mesh_end;

    pos_nxt       = pos_r;
    bnd_nxt       = bnd_r;
    finished_nxt  = finished_r;
    req.valid     = 1'b0;
    req.job.pos   = sk.pos;
    req.job.bnd   = bnd_new;

    if (accept) begin
      if (in_if.data.restart) begin
        bnd_nxt = bnd_new;
        if (sk.ok) begin
          pos_nxt      = sk.pos;
          finished_nxt = 1'b0;
          req.valid    = 1'b1;
        end else begin
          pos_nxt      = '0;
          finished_nxt = 1'b1;
        end
      end else if (fin_eff) begin
        finished_nxt = 1'b1;
      end else if (nx.ok) begin
        pos_nxt      = nx.pos;
        finished_nxt = 1'b0;
        req.valid    = 1'b1;
        req.job.pos  = nx.pos;
        req.job.bnd  = bnd_r;
      end else begin
        finished_nxt = 1'b1;
      end
    end else if (status.mesh_end) begin
      finished_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      bnd_r      <= '0;
      finished_r <= 1'b1;
    end else begin
      pos_r      <= pos_nxt;
      bnd_r      <= bnd_nxt;
      finished_r <= finished_nxt;
    end
  end

endmodule

FILE: design/gmi_emitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid mesh emitter
// Holds one job, forms its vertex indices and sends them one beat per cycle
// through the output register while out_if is ready, flagging the mesh end.
// ----------------------------------------------------------------------------
module gmi_emitter (
  input  logic                  clk,
  input  logic                  rst_n,
  input  gmi_pkg::cfg_t         cfg,
  input  gmi_pkg::job_req_t     req,
  output gmi_pkg::emit_status_t status,
  gmi_stream_if.source          out_if
);
  import gmi_pkg::*;

  localparam logic signed [STRIDE_W-1:0] STRIDE_TWO = STRIDE_W'(2);
  localparam logic [IDX_W-1:0]           IDX_ONE    = IDX_W'(1);
  localparam logic [CNT_W-1:0]           CNT_ONE    = CNT_W'(1);

  job_t                  job_r;
  job_t                  job_nxt;
  logic                  job_valid_r;
  logic                  job_valid_nxt;
  logic [CNT_W-1:0]      cnt_r;
  logic [CNT_W-1:0]      cnt_nxt;
  out_beat_t             beat_r;
  out_beat_t             beat_nxt;
  logic                  out_valid_r;
  logic                  out_valid_nxt;

  logic signed [STRIDE_W-1:0]         cols_s;
  logic signed [STRIDE_W-1:0]         stride;
  logic signed [COORD_W+STRIDE_W-1:0] prod;
  logic [IDX_W-1:0]                   rb;
  logic [IDX_W-1:0]                   kx;
  logic [IDX_W-1:0]                   sx;
  logic [IDX_W-1:0]                   exx;
  logic [IDX_W-1:0]                   base;
  logic [IDX_W-1:0]                   up;
  logic [IDX_W-1:0]                   vtx [MAX_RESULTS];
  logic [CNT_W-1:0]                   n_vtx;
  step_t                              after;
  logic                               done;
  logic                               last;
  logic                               out_load;
  logic                               emit;

  function automatic logic [IDX_W-1:0] widen(input logic signed [STRIDE_W-1:0] v);
    return {{(IDX_W-STRIDE_W){v[STRIDE_W-1]}}, v};
  endfunction

  // Index arithmetic wraps modulo the index width, so negative terms are
  // carried as sign-extended two's complement.
  always_comb begin
    cols_s = {{(STRIDE_W-DIM_W){1'b0}}, cfg.grid_columns};
    if (cfg.mesh_mode == MODE_FLAT_TRI || cfg.mesh_mode == MODE_FLAT_LINE) begin
      stride = (cols_s <<< 1) - STRIDE_TWO;
    end else begin
      stride = cols_s;
    end
    prod = (COORD_W+STRIDE_W)'(job_r.pos.i) * (COORD_W+STRIDE_W)'(stride);
    rb   = prod[IDX_W-1:0];
    kx   = widen(STRIDE_W'(job_r.pos.k));
    sx   = widen(stride);
    exx  = widen(STRIDE_W'(job_r.bnd.ex));

    base  = rb + kx;
    up    = base + sx;
    n_vtx = CNT_W'(2);
    for (int j = 0; j < MAX_RESULTS; j++) begin
      vtx[j] = base;
    end

    case (cfg.mesh_mode)
      MODE_SMOOTH_TRI, MODE_FLAT_TRI: begin
        if (cfg.mesh_mode == MODE_FLAT_TRI) begin
          base = rb + (kx << 1);
        end
        up     = base + sx;
        vtx[0] = base + IDX_ONE;
        vtx[1] = up;
        vtx[2] = base;
        vtx[3] = up + IDX_ONE;
        vtx[4] = up;
        vtx[5] = base + IDX_ONE;
        n_vtx  = CNT_W'(MAX_RESULTS);
      end
      MODE_SMOOTH_LINE: begin
        vtx[0] = base;
        vtx[1] = (job_r.pos.ph == PASS_FIRST) ? base + IDX_ONE : base + sx;
      end
      MODE_FLAT_LINE: begin
        if (job_r.pos.ph == PASS_FIRST) begin
          base   = rb + (kx << 1);
          vtx[0] = base;
          vtx[1] = base + IDX_ONE;
          vtx[2] = base;
          vtx[3] = base + sx;
          // The bottom row has no vertical pair.
          if (job_r.pos.i < job_r.bnd.ey) begin
            n_vtx = CNT_W'(4);
          end
        end else begin
          base   = rb + (exx << 1) - IDX_ONE;
          vtx[0] = base;
          vtx[1] = base + sx;
        end
      end
      default: n_vtx = CNT_W'(2);
    endcase

    after    = next_pos(job_r.pos, cfg.mesh_mode, job_r.bnd);
    done     = !after.ok;
    last     = (cnt_r == n_vtx - CNT_ONE);
    out_load = !out_valid_r || out_if.ready;
    emit     = job_valid_r && out_load;

    status.free     = !job_valid_r || (emit && last);
    status.mesh_end = job_valid_r && done;

    out_valid_nxt = out_valid_r;
    beat_nxt      = beat_r;
    if (out_load) begin
      out_valid_nxt = job_valid_r;
      if (job_valid_r) begin
        beat_nxt.vertex_index = vtx[cnt_r];
        beat_nxt.last_of_item = last;
        beat_nxt.mesh_done    = last && done;
      end
    end

    cnt_nxt = cnt_r;
    if (emit) begin
      cnt_nxt = last ? '0 : cnt_r + CNT_ONE;
    end

    job_nxt       = job_r;
    job_valid_nxt = job_valid_r;
    if (req.valid) begin
      job_nxt       = req.job;
      job_valid_nxt = 1'b1;
    end else if (emit && last) begin
      job_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      job_valid_r <= job_valid_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r  <= job_nxt;
    beat_r <= beat_nxt;
  end

  assign out_if.valid = out_valid_r;
  assign out_if.data  = beat_r;

endmodule

FILE: design/grid_mesh_index_generator_unit.sv
`timescale 1ns / 1ps
// An item's job is registered in the emitter's job register, then its first index in the
// output register. Indices leave one per cycle while the output is ready; an item gives
// 6 indices for triangles and 2 or 4 for lines, all through the single output register.
// A new beat is taken in the cycle the last index of the previous one is registered.
// Reset: all registers but the job and output data return to their defaults and the
// generator is finished, so only a restart produces indices.
// ----------------------------------------------------------------------------
// Grid mesh index generator
// Streams triangle or line vertex indices over a clamped region of a grid.
// ----------------------------------------------------------------------------
module grid_mesh_index_generator_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [gmi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gmi_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  gmi_stream_if.sink                      in_if,
  gmi_stream_if.source                    out_if
);
  import gmi_pkg::*;

  cfg_t         cfg;
  job_req_t     req;
  emit_status_t status;

  gmi_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  gmi_walker u_walker (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .status (status),
    .in_if  (in_if),
    .req    (req)
  );

  gmi_emitter u_emitter (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .req    (req),
    .status (status),
    .out_if (out_if)
  );

endmodule

FILE: sim/grid_mesh_index_generator_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid mesh index generator testbench
// Drives restart and advance beats into the generator and predicts the
// vertex index stream of every beat from a behavioral walk of the clamped
// region. Each output beat is checked against the oldest predicted index.
// A short directed part covers the modes, clamping, empty regions, tiny
// grids and live mode changes; random configurations and beats follow,
// with random gaps on both sides and one long output stall.
// ----------------------------------------------------------------------------
module grid_mesh_index_generator_unit_tb;
  import gmi_pkg::*;

  localparam int LIMIT     = 200000;
  localparam int STALL_AT  = 90;
  localparam int STALL_LEN = 300;
  localparam int GAP_PCT   = 22;

  typedef struct {
    int ph;
    int row;
    int col;
  } cursor_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  gmi_stream_if #(.payload_t(in_beat_t))  in_ch ();
  gmi_stream_if #(.payload_t(out_beat_t)) out_ch ();

  grid_mesh_index_generator_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_if     (in_ch),
    .out_if    (out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mirror of the registers and of the walker state.
  cfg_t      regs_mirror = CFG_RESET;
  cursor_t   walk        = '{0, 0, 0};
  bit        mesh_over   = 1'b1;
  int        lo_x, lo_y, hi_x, hi_y;

  in_beat_t  queued_beats[$];
  out_beat_t expected_indices[$];
  out_beat_t want;
  int        beats_taken;
  int        stall_left;
  bit        stall_used;
  bit        calm;
  int        faults;
  int        cycles;

  // Row and column span of one pass over the latched bounds; zero when the
  // pass does not exist in the current mode or is empty.
  function automatic bit cell_span(input int ph, output int r0, output int r1,
                                   output int c0, output int c1);
    r0 = lo_y;
    c0 = lo_x;
    r1 = 0;
    c1 = 0;
    if (ph > 1) return 1'b0;
    case (regs_mirror.mesh_mode)
      MODE_SMOOTH_TRI: begin
        if (ph != 0) return 1'b0;
        r1 = hi_y - 1;
        c1 = hi_x - 1;
      end
      MODE_SMOOTH_LINE: begin
        r1 = (ph == 0) ? hi_y : hi_y - 1;
        c1 = (ph == 0) ? hi_x - 1 : hi_x;
      end
      MODE_FLAT_TRI: begin
        if (ph != 0) return 1'b0;
        r1 = hi_y - 2;
        c1 = hi_x - 2;
      end
      default: begin
        if (ph == 0) begin
          r1 = hi_y;
          c1 = hi_x - 1;
        end else begin
          r1 = hi_y - 1;
          c0 = 0;
          c1 = 0;
        end
      end
    endcase
    return (r0 <= r1) && (c0 <= c1);
  endfunction

  function automatic bit first_cell(input int from_ph, output cursor_t p);
    int r0, r1, c0, c1;
    p = '{0, 0, 0};
    for (int ph = from_ph; ph <= 1; ph++) begin
      if (cell_span(ph, r0, r1, c0, c1)) begin
        p = '{ph, r0, c0};
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic bit step_cell(inout cursor_t p);
    int r0, r1, c0, c1;
    if (!cell_span(p.ph, r0, r1, c0, c1)) return first_cell(p.ph + 1, p);
    p.col++;
    if (p.col > c1) begin
      p.col = c0;
      p.row++;
    end
    if (p.row >= r0 && p.row <= r1 && p.col >= c0 && p.col <= c1) return 1'b1;
    return first_cell(p.ph + 1, p);
  endfunction

  // Works out the indices caused by one accepted beat and queues them.
  function automatic void predict_indices(input bit restart);
    cursor_t p, q;
    int      v[6];
    int      n, s, rb, b, up;
    int      c, r, x, y, ex, ey;
    bit      over;
    c  = int'(regs_mirror.grid_columns);
    r  = int'(regs_mirror.grid_rows);
    x  = int'(regs_mirror.start_x);
    y  = int'(regs_mirror.start_y);
    ex = int'(regs_mirror.end_x);
    ey = int'(regs_mirror.end_y);
    if (restart) begin
      // Flat triangles take the end bounds as counts, the others as last positions.
      if (regs_mirror.mesh_mode == MODE_FLAT_TRI) begin
        if (ex > c) ex = c;
        if (ey > r) ey = r;
      end else begin
        if (ex >= c) ex = c - 1;
        if (ey >= r) ey = r - 1;
      end
      if (x > ex) x = ex - 1;
      if (y > ey) y = ey - 1;
      lo_x = x;
      lo_y = y;
      hi_x = ex;
      hi_y = ey;
      if (!first_cell(0, p)) begin
        mesh_over = 1'b1;
        walk      = '{0, 0, 0};
        return;
      end
    end else begin
      if (mesh_over) return;
      p = walk;
      if (!step_cell(p)) begin
        mesh_over = 1'b1;
        return;
      end
    end
    mesh_over = 1'b0;
    walk      = p;

    s  = regs_mirror.mesh_mode[1] ? 2 * c - 2 : c;
    rb = p.row * s;
    case (regs_mirror.mesh_mode)
      MODE_SMOOTH_TRI, MODE_FLAT_TRI: begin
        b  = (regs_mirror.mesh_mode == MODE_SMOOTH_TRI) ? rb + p.col : rb + 2 * p.col;
        up = b + s;
        v  = '{b + 1, up, b, up + 1, up, b + 1};
        n  = 6;
      end
      MODE_SMOOTH_LINE: begin
        b    = rb + p.col;
        v[0] = b;
        v[1] = (p.ph == 0) ? b + 1 : b + s;
        n    = 2;
      end
      default: begin
        if (p.ph == 0) begin
          b    = rb + 2 * p.col;
          v[0] = b;
          v[1] = b + 1;
          n    = 2;
          // The vertical pair is dropped on the last row of the region.
          if (p.row < hi_y) begin
            v[2] = b;
            v[3] = b + s;
            n    = 4;
          end
        end else begin
          b    = rb + 2 * hi_x - 1;
          v[0] = b;
          v[1] = b + s;
          n    = 2;
        end
      end
    endcase

    q    = p;
    over = !step_cell(q);
    if (over) mesh_over = 1'b1;
    for (int j = 0; j < n; j++) begin
      expected_indices.push_back('{vertex_index: IDX_W'(v[j]),
                                   last_of_item: (j == n - 1),
                                   mesh_done:    (j == n - 1) && over});
    end
  endfunction

  // Input driver: one beat per handshake, random gaps unless calm.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      beats_taken <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_indices(in_ch.data.restart);
        beats_taken <= beats_taken + 1;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (queued_beats.size() != 0 && (calm || $urandom_range(99) >= GAP_PCT)) begin
          in_ch.valid <= 1'b1;
          in_ch.data  <= queued_beats.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // One long output hold-off so the generator backs up into its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left <= 0;
      stall_used <= 1'b0;
    end else if (!stall_used && beats_taken >= STALL_AT) begin
      stall_left <= STALL_LEN;
      stall_used <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // Output monitor and checker.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_indices.size() == 0) begin
          if (faults < 10)
            $display("unexpected index beat: index %0d last %0b done %0b",
                     out_ch.data.vertex_index, out_ch.data.last_of_item,
                     out_ch.data.mesh_done);
          faults++;
        end else begin
          want = expected_indices.pop_front();
          if (out_ch.data.vertex_index !== want.vertex_index ||
              out_ch.data.last_of_item !== want.last_of_item ||
              out_ch.data.mesh_done !== want.mesh_done) begin
            if (faults < 10)
              $display("index mismatch: expected %0d/%0b/%0b got %0d/%0b/%0b",
                       want.vertex_index, want.last_of_item, want.mesh_done,
                       out_ch.data.vertex_index, out_ch.data.last_of_item,
                       out_ch.data.mesh_done);
            faults++;
          end
        end
      end
      out_ch.ready <= (stall_left == 0) && (calm || $urandom_range(99) >= GAP_PCT);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // A negative value leaves the register untouched.
  task automatic put_reg(input cfg_reg_t which, input int value);
    logic [CFG_DATA_W-1:0] w;
    if (value < 0) return;
    w = value[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= which;
    cfg_wdata <= w;
    case (which)
      REG_GRID_COLUMNS: regs_mirror.grid_columns = (w > MAX_DIM) ? DIM_W'(MAX_DIM) : w;
      REG_GRID_ROWS:    regs_mirror.grid_rows = (w > MAX_DIM) ? DIM_W'(MAX_DIM) : w;
      REG_START_X:      regs_mirror.start_x = w[POS_W-1:0];
      REG_START_Y:      regs_mirror.start_y = w[POS_W-1:0];
      REG_END_X:        regs_mirror.end_x = w[POS_W-1:0];
      REG_END_Y:        regs_mirror.end_y = w[POS_W-1:0];
      REG_MESH_MODE:    regs_mirror.mesh_mode = mesh_mode_t'(w[1:0]);
      default: ;
    endcase
  endtask

  task automatic load_regs(input int cols, input int rows, input int sx, input int sy,
                           input int ex, input int ey, input int mode);
    put_reg(REG_GRID_COLUMNS, cols);
    put_reg(REG_GRID_ROWS, rows);
    put_reg(REG_START_X, sx);
    put_reg(REG_START_Y, sy);
    put_reg(REG_END_X, ex);
    put_reg(REG_END_Y, ey);
    put_reg(REG_MESH_MODE, mode);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_items(input bit lead, input int advances, input int restart_pct);
    in_beat_t b;
    @(negedge clk);
    b.restart = lead;
    queued_beats.push_back(b);
    repeat (advances) begin
      b.restart = ($urandom_range(99) < restart_pct);
      queued_beats.push_back(b);
    end
  endtask

  // Waits for everything to drain, then gives beats that cause no index
  // time to leave the pipeline.
  task automatic settle();
    do @(negedge clk);
    while (queued_beats.size() != 0 || in_ch.valid || expected_indices.size() != 0);
    repeat (10) @(negedge clk);
  endtask

  function automatic int pick_dim();
    int sel;
    sel = $urandom_range(19);
    if (sel == 0) return $urandom_range(1);
    if (sel == 1) return $urandom_range(256, 511);
    return $urandom_range(2, 12);
  endfunction

  function automatic int pick_start();
    if ($urandom_range(4) == 0) return $urandom_range(511);
    return $urandom_range(6);
  endfunction

  function automatic int pick_end();
    if ($urandom_range(4) == 0) return $urandom_range(511);
    return $urandom_range(1, 12);
  endfunction

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = REG_GRID_COLUMNS;
    cfg_wdata    = '0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    calm         = 1'b0;
    faults       = 0;
    cycles       = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Advance straight out of reset, then the default one-cell mesh.
    run_items(1'b0, 0, 0);
    settle();
    run_items(1'b1, 1, 0);
    settle();

    // Largest grid, with saturating dimension writes.
    load_regs(511, 256, 0, 0, 255, 255, MODE_SMOOTH_LINE);
    run_items(1'b1, 2, 0);
    settle();

    // One-column, one-row grid: starts clamp below zero and indices wrap.
    load_regs(1, 1, 5, 5, 9, 9, MODE_SMOOTH_TRI);
    run_items(1'b1, 1, 0);
    settle();

    // Flat triangles at the far corner: first an empty region, then two cells.
    load_regs(256, 256, 254, 253, 255, 255, MODE_FLAT_TRI);
    run_items(1'b1, 0, 0);
    settle();
    load_regs(-1, -1, 252, -1, -1, -1, -1);
    run_items(1'b1, 2, 0);
    settle();

    // Flat grid lines with clamped ends, walked to the end of the rightmost column.
    load_regs(3, 3, 0, 0, 200, 200, MODE_FLAT_LINE);
    run_items(1'b1, 8, 0);
    settle();

    // Start beyond the end, then a mode change in the middle of the mesh.
    load_regs(4, 3, 255, 0, 3, 2, MODE_SMOOTH_LINE);
    run_items(1'b1, 2, 0);
    settle();
    load_regs(-1, -1, -1, -1, -1, -1, MODE_FLAT_LINE);
    run_items(1'b0, 2, 0);

    for (int round = 0; round < 8; round++) begin
      settle();
      calm = (round == 3);
      if (round != 0 && $urandom_range(3) == 0) begin
        load_regs($urandom_range(1) ? pick_dim() : -1, -1, -1, -1, -1, -1,
                  $urandom_range(3));
        run_items(1'b0, 27, 8);
      end else begin
        load_regs(pick_dim(), pick_dim(), pick_start(), pick_start(), pick_end(),
                  pick_end(), $urandom_range(3));
        run_items(1'b1, 27, 10);
      end
    end

    settle();
    if (faults == 0 && expected_indices.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
